### hw/rtl/sfr_pkg.sv
// Shared types and constants of the sensor frame receiver.
package sfr_pkg;

   localparam int COUNT_W = 6;
   localparam int TICK_W = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_BAD_HEADER = 3'd1;
   localparam logic [2:0] STATUS_BAD_TAIL = 3'd2;
   localparam logic [2:0] STATUS_BAD_SUM = 3'd3;
   localparam logic [2:0] STATUS_TIMEOUT = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_FIRST = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TAIL_FIRST = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TAIL_SECOND = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_TICKS = 3'd4;

   localparam logic [7:0] LENGTH_OVERHEAD = 8'd3;

   typedef struct packed {
      logic       ld_first;
      logic       ld_length;
      logic       ld_command;
      logic       ld_pay;
      logic       ld_checksum;
      logic       tick_inc;
      logic       tick_clr;
      logic       emit_status;
      logic [2:0] status_code;
      logic       show_cmd;
      logic       show_len;
      logic       show_sum;
      logic       run_start;
      logic       run_read;
      logic       run_emit;
   } sfr_cmd_type;

   typedef struct packed {
      logic header_ok;
      logic tail_ok;
      logic sum_ok;
      logic target_zero;
      logic pay_done;
      logic timeout_hit;
      logic run_last;
      logic out_free;
   } sfr_stat_type;

endpackage

### hw/rtl/sensor_frame_receiver_top.sv
// Sensor frame receiver top level: controller and datapath.
//
// Request channel: one transaction per received byte (req_action 0) or per
// time tick (req_action 1). Frames are header, header, length, command,
// payload, checksum, tail, tail; header and tail bytes and the per-group tick
// timeout come from the csr_ write port; the user must write them only while
// the block is idle, as the block does not enforce it. Response channel: a
// finished frame gives one status transaction, or a run of payload
// transactions with rsp_last on the final one. A status result is registered
// at the accepting edge and appears in the cycle after it; each result
// of a payload run follows a payload memory read and then a result load. One
// request per cycle while req_stall is low; a good frame with N payload bytes
// then gives a run of N results, during which req_stall stays high.
// A stalled response holds its result register; req_stall rises while the
// held result cannot be replaced.
// Reset clears the parser to await the first header byte and clears the
// configuration registers to zero; it needs no clearing pass.
module sensor_frame_receiver_top
   import sfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_command,
   output logic [7:0]             rsp_frame_length,
   output logic [7:0]             rsp_received_sum,
   output logic [7:0]             rsp_payload_byte,
   output logic [4:0]             rsp_payload_index,
   output logic                   rsp_payload_valid,
   output logic                   rsp_last,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   sfr_cmd_type  cmd;
   sfr_stat_type stat;

   sfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   sfr_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_command       (rsp_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_received_sum  (rsp_received_sum),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_last          (rsp_last)
   );

endmodule

### hw/rtl/sfr_ctrl.sv
// Frame parsing controller: phase sequencing and payload run sequencing.
module sfr_ctrl
   import sfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_action,
   output logic         req_stall,
   input  sfr_stat_type stat,
   output sfr_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_H0,
      ST_H1,
      ST_LEN,
      ST_CMD,
      ST_PAY,
      ST_SUM,
      ST_T0,
      ST_T1,
      ST_RUN_RD,
      ST_RUN_LD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      byte_phase;
   logic      accept;

   assign byte_phase = (state_ff != ST_RUN_RD) && (state_ff != ST_RUN_LD);
   assign req_stall = !(byte_phase && stat.out_free);
   assign accept = req_valid && !req_stall;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      cmd.show_cmd = (state_ff == ST_PAY) || (state_ff == ST_SUM) ||
                     (state_ff == ST_T0) || (state_ff == ST_T1);
      cmd.show_len = cmd.show_cmd || (state_ff == ST_CMD);
      cmd.show_sum = (state_ff == ST_T0) || (state_ff == ST_T1);
      if (accept && req_action) begin
         if (state_ff != ST_H0) begin
            if (stat.timeout_hit) begin
               cmd.emit_status = 1'b1;
               cmd.status_code = STATUS_TIMEOUT;
               cmd.tick_clr = 1'b1;
               state_in = ST_H0;
            end else begin
               cmd.tick_inc = 1'b1;
            end
         end
      end else if (accept) begin
         unique case (state_ff)
            ST_H0: begin
               cmd.ld_first = 1'b1;
               cmd.tick_clr = 1'b1;
               state_in = ST_H1;
            end
            ST_H1: begin
               cmd.tick_clr = 1'b1;
               if (!stat.header_ok) begin
                  cmd.emit_status = 1'b1;
                  cmd.status_code = STATUS_BAD_HEADER;
                  state_in = ST_H0;
               end else begin
                  state_in = ST_LEN;
               end
            end
            ST_LEN: begin
               cmd.ld_length = 1'b1;
               cmd.tick_clr = 1'b1;
               state_in = ST_CMD;
            end
            ST_CMD: begin
               cmd.ld_command = 1'b1;
               cmd.tick_clr = 1'b1;
               state_in = stat.target_zero ? ST_SUM : ST_PAY;
            end
            ST_PAY: begin
               cmd.ld_pay = 1'b1;
               if (stat.pay_done) begin
                  cmd.tick_clr = 1'b1;
                  state_in = ST_SUM;
               end
            end
            ST_SUM: begin
               cmd.ld_checksum = 1'b1;
               cmd.tick_clr = 1'b1;
               state_in = ST_T0;
            end
            ST_T0: begin
               cmd.ld_first = 1'b1;
               state_in = ST_T1;
            end
            ST_T1: begin
               cmd.tick_clr = 1'b1;
               state_in = ST_H0;
               if (!stat.tail_ok) begin
                  cmd.emit_status = 1'b1;
                  cmd.status_code = STATUS_BAD_TAIL;
               end else if (!stat.sum_ok) begin
                  cmd.emit_status = 1'b1;
                  cmd.status_code = STATUS_BAD_SUM;
               end else if (stat.target_zero) begin
                  cmd.emit_status = 1'b1;
                  cmd.status_code = STATUS_OK;
               end else begin
                  cmd.run_start = 1'b1;
                  state_in = ST_RUN_RD;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end else if (state_ff == ST_RUN_RD) begin
         cmd.run_read = 1'b1;
         state_in = ST_RUN_LD;
      end else if (state_ff == ST_RUN_LD && stat.out_free) begin
         cmd.run_emit = 1'b1;
         state_in = stat.run_last ? ST_H0 : ST_RUN_RD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_H0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/sfr_datapath.sv
// Frame receiver datapath: field holds, checksum, tick counter, payload memory, result register.
module sfr_datapath
   import sfr_pkg::*;
#(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_rx_byte,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  sfr_cmd_type            cmd,
   output sfr_stat_type           stat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_command,
   output logic [7:0]             rsp_frame_length,
   output logic [7:0]             rsp_received_sum,
   output logic [7:0]             rsp_payload_byte,
   output logic [4:0]             rsp_payload_index,
   output logic                   rsp_payload_valid,
   output logic                   rsp_last
);

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [7:0] MAX_BYTE = 8'(MAX_PAYLOAD);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PAYLOAD);

   logic [7:0]         header_first_ff;
   logic [7:0]         header_second_ff;
   logic [7:0]         tail_first_ff;
   logic [7:0]         tail_second_ff;
   logic [TICK_W-1:0]  timeout_ff;

   logic [7:0]         first_ff;
   logic [7:0]         length_ff;
   logic [7:0]         command_ff;
   logic [7:0]         checksum_ff;
   logic [7:0]         sum_ff;
   logic [COUNT_W-1:0] target_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] run_idx_ff;
   logic [TICK_W-1:0]  tick_ff;
   logic [TICK_W-1:0]  tick_in;
   logic [7:0]         mem [MAX_PAYLOAD];
   logic [7:0]         mem_rd_ff;

   logic [7:0]         diff;
   logic [COUNT_W-1:0] target_in;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   logic [7:0]         rsp_command_ff;
   logic [7:0]         rsp_frame_length_ff;
   logic [7:0]         rsp_received_sum_ff;
   logic [7:0]         rsp_payload_byte_ff;
   logic [4:0]         rsp_payload_index_ff;
   logic               rsp_payload_valid_ff;
   logic               rsp_last_ff;

   assign diff = req_rx_byte - LENGTH_OVERHEAD;
   assign target_in = (req_rx_byte < LENGTH_OVERHEAD || diff > MAX_BYTE) ?
                      MAX_COUNT : diff[COUNT_W-1:0];
   assign tick_in = (tick_ff == {TICK_W{1'b1}}) ? tick_ff : tick_ff + TICK_W'(1);

   assign stat.header_ok = (first_ff == header_first_ff) && (req_rx_byte == header_second_ff);
   assign stat.tail_ok = (first_ff == tail_first_ff) && (req_rx_byte == tail_second_ff);
   assign stat.sum_ok = (sum_ff == checksum_ff);
   assign stat.target_zero = (target_ff == '0);
   assign stat.pay_done = ({1'b0, count_ff} + (COUNT_W+1)'(1)) >= {1'b0, target_ff};
   assign stat.timeout_hit = (timeout_ff != '0) && (tick_in >= timeout_ff);
   assign stat.run_last = ({1'b0, run_idx_ff} + (COUNT_W+1)'(1)) == {1'b0, target_ff};
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff <= '0;
         header_second_ff <= '0;
         tail_first_ff <= '0;
         tail_second_ff <= '0;
         timeout_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_HEADER_FIRST:  header_first_ff <= csr_data[7:0];
            REG_HEADER_SECOND: header_second_ff <= csr_data[7:0];
            REG_TAIL_FIRST:    tail_first_ff <= csr_data[7:0];
            REG_TAIL_SECOND:   tail_second_ff <= csr_data[7:0];
            REG_TIMEOUT_TICKS: timeout_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (cmd.tick_clr) begin
         tick_ff <= '0;
      end else if (cmd.tick_inc) begin
         tick_ff <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_first) begin
         first_ff <= req_rx_byte;
      end
      if (cmd.ld_length) begin
         length_ff <= req_rx_byte;
         sum_ff <= req_rx_byte;
         target_ff <= target_in;
      end
      if (cmd.ld_command) begin
         command_ff <= req_rx_byte;
         sum_ff <= sum_ff + req_rx_byte;
         count_ff <= '0;
      end
      if (cmd.ld_pay) begin
         mem[count_ff[ADDR_W-1:0]] <= req_rx_byte;
         count_ff <= count_ff + COUNT_W'(1);
         sum_ff <= sum_ff + req_rx_byte;
      end
      if (cmd.ld_checksum) begin
         checksum_ff <= req_rx_byte;
      end
      if (cmd.run_start) begin
         run_idx_ff <= '0;
      end else if (cmd.run_emit) begin
         run_idx_ff <= run_idx_ff + COUNT_W'(1);
      end
      if (cmd.run_read) begin
         mem_rd_ff <= mem[run_idx_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_status || cmd.run_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_status) begin
         rsp_status_ff <= cmd.status_code;
         rsp_command_ff <= cmd.show_cmd ? command_ff : 8'd0;
         rsp_frame_length_ff <= cmd.show_len ? length_ff : 8'd0;
         rsp_received_sum_ff <= cmd.show_sum ? checksum_ff : 8'd0;
         rsp_payload_byte_ff <= 8'd0;
         rsp_payload_index_ff <= 5'd0;
         rsp_payload_valid_ff <= 1'b0;
         rsp_last_ff <= 1'b1;
      end else if (cmd.run_emit) begin
         rsp_status_ff <= STATUS_OK;
         rsp_command_ff <= command_ff;
         rsp_frame_length_ff <= length_ff;
         rsp_received_sum_ff <= checksum_ff;
         rsp_payload_byte_ff <= mem_rd_ff;
         rsp_payload_index_ff <= run_idx_ff[4:0];
         rsp_payload_valid_ff <= 1'b1;
         rsp_last_ff <= stat.run_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_command = rsp_command_ff;
   assign rsp_frame_length = rsp_frame_length_ff;
   assign rsp_received_sum = rsp_received_sum_ff;
   assign rsp_payload_byte = rsp_payload_byte_ff;
   assign rsp_payload_index = rsp_payload_index_ff;
   assign rsp_payload_valid = rsp_payload_valid_ff;
   assign rsp_last = rsp_last_ff;

endmodule

### tb/tb_sensor_frame_receiver_top.sv
// Self-checking testbench of the sensor frame receiver with a frame parser scoreboard.
module tb_sensor_frame_receiver_top;
   import sfr_pkg::*;

   localparam int PAYLOAD_CAP = 32;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEMS_PER_STAGE = 105;
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef enum logic [2:0] {
      AWAIT_H0,
      AWAIT_H1,
      AWAIT_LEN,
      AWAIT_CMD,
      AWAIT_PAY,
      AWAIT_SUM,
      AWAIT_T0,
      AWAIT_T1
   } parse_phase_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] command;
      logic [7:0] frame_length;
      logic [7:0] received_sum;
      logic [7:0] payload_byte;
      logic [4:0] payload_index;
      logic       payload_valid;
      logic       last;
   } frame_result_type;

   class frame_scoreboard;
      logic [7:0]       hdr_first, hdr_second, tl_first, tl_second;
      logic [15:0]      tick_limit;
      parse_phase_type  phase;
      logic [7:0]       first_hold, len_hold, cmd_hold, sum_hold, byte_sum;
      logic [5:0]       target, count;
      logic [7:0]       store [PAYLOAD_CAP];
      logic [15:0]      ticks;
      frame_result_type expected_q[$];
      int               mismatches;

      function new();
         hdr_first = '0;
         hdr_second = '0;
         tl_first = '0;
         tl_second = '0;
         tick_limit = '0;
         phase = AWAIT_H0;
         first_hold = '0;
         len_hold = '0;
         cmd_hold = '0;
         sum_hold = '0;
         byte_sum = '0;
         target = '0;
         count = '0;
         ticks = '0;
         mismatches = 0;
         foreach (store[i]) store[i] = '0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_HEADER_FIRST: hdr_first = val[7:0];
            REG_HEADER_SECOND: hdr_second = val[7:0];
            REG_TAIL_FIRST: tl_first = val[7:0];
            REG_TAIL_SECOND: tl_second = val[7:0];
            REG_TIMEOUT_TICKS: tick_limit = val;
            default: ;
         endcase
      endfunction

      function void close_frame(logic [2:0] st);
         frame_result_type res;
         res = '0;
         res.status = st;
         res.command = (phase >= AWAIT_PAY) ? cmd_hold : 8'h00;
         res.frame_length = (phase >= AWAIT_CMD) ? len_hold : 8'h00;
         res.received_sum = (phase >= AWAIT_T0) ? sum_hold : 8'h00;
         res.last = 1'b1;
         expected_q.push_back(res);
         phase = AWAIT_H0;
         ticks = '0;
      endfunction

      function void note_request(logic act, logic [7:0] b);
         frame_result_type res;
         int kept;
         if (act == ACT_TICK) begin
            if (phase == AWAIT_H0) return;
            if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
            if (tick_limit != 16'd0 && ticks >= tick_limit) close_frame(STATUS_TIMEOUT);
            return;
         end
         case (phase)
            AWAIT_H0: begin
               first_hold = b;
               ticks = '0;
               phase = AWAIT_H1;
            end
            AWAIT_H1: begin
               if (first_hold != hdr_first || b != hdr_second) begin
                  close_frame(STATUS_BAD_HEADER);
               end else begin
                  phase = AWAIT_LEN;
                  ticks = '0;
               end
            end
            AWAIT_LEN: begin
               len_hold = b;
               byte_sum = b;
               kept = int'(b) - int'(LENGTH_OVERHEAD);
               if (kept < 0 || kept > PAYLOAD_CAP) kept = PAYLOAD_CAP;
               target = 6'(kept);
               phase = AWAIT_CMD;
               ticks = '0;
            end
            AWAIT_CMD: begin
               cmd_hold = b;
               byte_sum = byte_sum + b;
               count = '0;
               phase = (target == 6'd0) ? AWAIT_SUM : AWAIT_PAY;
               ticks = '0;
            end
            AWAIT_PAY: begin
               if (count < target) store[count] = b;
               count = count + 6'd1;
               byte_sum = byte_sum + b;
               if (count >= target) begin
                  phase = AWAIT_SUM;
                  ticks = '0;
               end
            end
            AWAIT_SUM: begin
               sum_hold = b;
               phase = AWAIT_T0;
               ticks = '0;
            end
            AWAIT_T0: begin
               first_hold = b;
               phase = AWAIT_T1;
            end
            default: begin
               if (first_hold != tl_first || b != tl_second) begin
                  close_frame(STATUS_BAD_TAIL);
               end else if (byte_sum != sum_hold) begin
                  close_frame(STATUS_BAD_SUM);
               end else if (target == 6'd0) begin
                  close_frame(STATUS_OK);
               end else begin
                  for (int i = 0; i < int'(target); i++) begin
                     res.status = STATUS_OK;
                     res.command = cmd_hold;
                     res.frame_length = len_hold;
                     res.received_sum = sum_hold;
                     res.payload_byte = store[i];
                     res.payload_index = 5'(i);
                     res.payload_valid = 1'b1;
                     res.last = (i + 1 == int'(target));
                     expected_q.push_back(res);
                  end
                  phase = AWAIT_H0;
                  ticks = '0;
               end
            end
         endcase
      endfunction

      function void check_response(frame_result_type got);
         frame_result_type exp;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected: st=%0d cmd=%h len=%h sum=%h byte=%h idx=%0d pv=%b last=%b",
                        got.status, got.command, got.frame_length, got.received_sum,
                        got.payload_byte, got.payload_index, got.payload_valid, got.last);
            return;
         end
         exp = expected_q.pop_front();
         if (got.status !== exp.status || got.command !== exp.command ||
             got.frame_length !== exp.frame_length || got.received_sum !== exp.received_sum ||
             got.payload_byte !== exp.payload_byte || got.payload_index !== exp.payload_index ||
             got.payload_valid !== exp.payload_valid || got.last !== exp.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response mismatch at %0t", $time);
               $display("  expected st=%0d cmd=%h len=%h sum=%h byte=%h idx=%0d pv=%b last=%b",
                        exp.status, exp.command, exp.frame_length, exp.received_sum,
                        exp.payload_byte, exp.payload_index, exp.payload_valid, exp.last);
               $display("  actual   st=%0d cmd=%h len=%h sum=%h byte=%h idx=%0d pv=%b last=%b",
                        got.status, got.command, got.frame_length, got.received_sum,
                        got.payload_byte, got.payload_index, got.payload_valid, got.last);
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_action = 1'b0;
   logic [7:0]             req_rx_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [2:0]             rsp_status;
   logic [7:0]             rsp_command;
   logic [7:0]             rsp_frame_length;
   logic [7:0]             rsp_received_sum;
   logic [7:0]             rsp_payload_byte;
   logic [4:0]             rsp_payload_index;
   logic                   rsp_payload_valid;
   logic                   rsp_last;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int              send_idle_pct = 7;
   int              recv_idle_pct = 56;
   int              quiet_cycles = 0;
   frame_scoreboard scoreboard = new;

   sensor_frame_receiver_top #(
      .MAX_PAYLOAD(PAYLOAD_CAP)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_command(rsp_command),
      .rsp_frame_length(rsp_frame_length),
      .rsp_received_sum(rsp_received_sum),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_payload_index(rsp_payload_index),
      .rsp_payload_valid(rsp_payload_valid),
      .rsp_last(rsp_last),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) scoreboard.note_request(req_action, req_rx_byte);
         if (rsp_valid && !rsp_stall)
            scoreboard.check_response(frame_result_type'{
               rsp_status, rsp_command, rsp_frame_length, rsp_received_sum,
               rsp_payload_byte, rsp_payload_index, rsp_payload_valid, rsp_last});
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_item(input logic act, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      scoreboard.set_reg(idx, val);
   endtask

   task automatic configure(input logic [7:0] h0, input logic [7:0] h1, input logic [7:0] t0,
                            input logic [7:0] t1, input logic [15:0] limit);
      write_reg(REG_HEADER_FIRST, {8'h00, h0});
      write_reg(REG_HEADER_SECOND, {8'h00, h1});
      write_reg(REG_TAIL_FIRST, {8'h00, t0});
      write_reg(REG_TAIL_SECOND, {8'h00, t1});
      write_reg(REG_TIMEOUT_TICKS, limit);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // hold until every expected transaction has arrived, then let the block settle
   task automatic drain_responses();
      @(posedge clock);
      while (scoreboard.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_frame(input int tick_chance, inout int sent);
      logic [7:0] frame[$];
      logic [7:0] len, cmd, sum, b;
      int         kept, sel, pos;
      sel = $urandom_range(99);
      if (sel < 80) len = 8'($urandom_range(3, 10));
      else if (sel < 88) len = 8'($urandom_range(0, 2));
      else if (sel < 94) len = 8'($urandom_range(11, 34));
      else if (sel < 97) len = 8'd35;
      else len = 8'($urandom_range(36, 255));
      kept = int'(len) - int'(LENGTH_OVERHEAD);
      if (kept < 0 || kept > PAYLOAD_CAP) kept = PAYLOAD_CAP;
      cmd = 8'($urandom);
      sum = len + cmd;
      frame = {scoreboard.hdr_first, scoreboard.hdr_second, len, cmd};
      repeat (kept) begin
         b = 8'($urandom);
         sum = sum + b;
         frame.push_back(b);
      end
      frame.push_back(sum);
      frame.push_back(scoreboard.tl_first);
      frame.push_back(scoreboard.tl_second);
      sel = $urandom_range(99);
      if (sel < 8) begin
         pos = $urandom_range(1);
         frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
      end else if (sel < 16) begin
         pos = frame.size() - 3;
         frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
      end else if (sel < 24) begin
         pos = frame.size() - 1 - $urandom_range(1);
         frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
      end else if (sel < 28) begin
         frame.delete($urandom_range(frame.size() - 1));
      end
      foreach (frame[i]) begin
         if ($urandom_range(99) < tick_chance)
            repeat ($urandom_range(1, 3)) begin
               send_item(ACT_TICK, 8'($urandom));
               sent++;
            end
         send_item(ACT_BYTE, frame[i]);
         sent++;
      end
   endtask

   task automatic run_stage(input int tick_chance);
      int sent;
      sent = 0;
      while (sent < ITEMS_PER_STAGE) begin
         if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) begin
               send_item(1'($urandom), 8'($urandom));
               sent++;
            end
         send_frame(tick_chance, sent);
      end
      req_valid <= 1'b0;
      drain_responses();
   endtask

   initial begin
      logic [7:0] directed_bytes[$];
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      configure(8'hAA, 8'h55, 8'h0D, 8'h0A, 16'd3);

      // idle tick, bad header, empty frame, bad tail over bad checksum, two-byte payload
      send_item(ACT_TICK, 8'h00);
      directed_bytes = {8'h00, 8'hFF,
                        8'hAA, 8'h55, 8'h03, 8'hFF, 8'h02, 8'h0D, 8'h0A,
                        8'hAA, 8'h55, 8'h03, 8'h00, 8'h55, 8'h0D, 8'h0B,
                        8'hAA, 8'h55, 8'h05, 8'h00, 8'h00, 8'hFF, 8'h04, 8'h0D, 8'h0A,
                        8'hAA};
      foreach (directed_bytes[i]) send_item(ACT_BYTE, directed_bytes[i]);
      // open frame expires on the third tick
      repeat (3) send_item(ACT_TICK, 8'hFF);
      req_valid <= 1'b0;
      drain_responses();

      configure(8'h00, 8'hFF, 8'hFF, 8'h00, 16'hFFFF);
      run_stage(10);

      send_idle_pct = 56;
      recv_idle_pct = 7;
      configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                16'($urandom_range(1, 6)));
      run_stage(8);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(8'hFF, 8'h00, 8'h00, 8'hFF, 16'd0);
      run_stage(5);

      repeat (16) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.expected_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_ctrl.sv
hw/rtl/sfr_datapath.sv
hw/rtl/sensor_frame_receiver_top.sv
tb/tb_sensor_frame_receiver_top.sv
